// ===== rtl/mrzs_pkg.sv =====
`default_nettype none
package mrzs_pkg;

	// Width of the constants loaded at the start of a scan.
	localparam int unsigned CONST_WIDTH = 12;
	// Number of constants converted at start: four cubic, seven sixth, two terms.
	localparam int unsigned INIT_NUM = 13;
	localparam int unsigned INIT_IDX_WIDTH = 4;
	localparam int unsigned CUBIC_NUM = 4;
	localparam int unsigned SIXTH_NUM = 7;
	localparam int unsigned FIELD_WIDTH = 31;

	localparam logic [INIT_IDX_WIDTH-1:0] IDX_SIXTH_FIRST = 4'd4;
	localparam logic [INIT_IDX_WIDTH-1:0] IDX_PREV = 4'd11;
	localparam logic [INIT_IDX_WIDTH-1:0] IDX_CUR = 4'd12;

	// Difference rows at r = 1, then c(0) and c(1).
	localparam logic [CONST_WIDTH-1:0] INIT_CONST [INIT_NUM] = '{
		12'd117, 12'd418, 12'd510, 12'd204,
		12'd1, 12'd63, 12'd602, 12'd2100, 12'd3360, 12'd2520, 12'd720,
		12'd1, 12'd5
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_GO,
		ST_INIT_WAIT,
		ST_M1_GO,
		ST_M1_WAIT,
		ST_M2_GO,
		ST_M2_WAIT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/mrzs_mulmod.sv =====
`default_nettype none
// Bit-serial modular multiplier: result = a * b mod p, one bit of a per
// cycle, most significant first. Requires b < p and p odd above 2.
module mrzs_mulmod #(
	parameter int unsigned W = 31,
	parameter int unsigned AW = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] a,
	input  wire logic [W-1:0]  b,
	input  wire logic [W-1:0]  p,
	output logic               done,
	output logic [W-1:0]       result
);

	localparam int unsigned CW = $clog2(AW);

	logic [AW-1:0] a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   dbl;
	logic [W-1:0] dbl_red;
	logic [W:0]   sum;
	logic [W-1:0] sum_red;

	// One iteration: double, reduce, add the partial product, reduce.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, p}) ? W'(dbl - {1'b0, p}) : dbl[W-1:0];
		sum = {1'b0, dbl_red} + (a_q[AW-1] ? {1'b0, b_q} : '0);
		sum_red = (sum >= {1'b0, p}) ? W'(sum - {1'b0, p}) : sum[W-1:0];
	end

	// Control of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand shift register and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[AW-2:0], 1'b0};
			acc_q <= sum_red;
		end
	end

	assign done = done_q;
	assign result = acc_q;

endmodule
`default_nettype wire

// ===== rtl/modular_recurrence_zero_scan_top.sv =====
`default_nettype none
// Scanner for zeros of the recurrence
// c(r+1) = (34r^3+51r^2+27r+5) c(r) - r^6 c(r-1) modulo an odd modulus.
// The modulus is to be written through modulus_wr/modulus only while the block is
// idle, which the block itself does not enforce; a write ends any scan in progress.
// Input channel: one word per step, start_req = 1 starts a scan at r = 1.
// Output channel: one word per input word, with step_valid, term_index,
// zero_hit and last_step. Idle words and a refused start give all zeros.
// A continuing step runs two products through the multiplier before its output
// word is offered, the operand width AW being the larger of MOD_WIDTH and 12; a
// start first converts the 13 initial constants. All products go through the
// single bit-serial modular multiplier, one bit of the operand per cycle.
// One word is processed at a time; the next input word is taken once the
// result has moved to the output register, so one result may wait there.
// When the receiver stalls, the output word holds and a finished result
// waits in the core until the output register frees.
// Reset clears the scan state; the modulus returns to 7.
module modular_recurrence_zero_scan_top #(
	parameter int unsigned MOD_WIDTH = 31
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                modulus_wr,
	input  wire logic [mrzs_pkg::FIELD_WIDTH-1:0]    modulus,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                start_req,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     step_valid,
	output logic [mrzs_pkg::FIELD_WIDTH-1:0]         term_index,
	output logic                                     zero_hit,
	output logic                                     last_step
);

	localparam int unsigned W = MOD_WIDTH;
	localparam int unsigned AW = (W > mrzs_pkg::CONST_WIDTH) ? W : mrzs_pkg::CONST_WIDTH;
	localparam int unsigned IW = mrzs_pkg::INIT_IDX_WIDTH;

	mrzs_pkg::state_t state_q, state_d;

	logic [W-1:0] p_q;
	logic [W-1:0] prev_q, cur_q, t1_q, r_q;
	logic [W-1:0] cubic_q [mrzs_pkg::CUBIC_NUM];
	logic [W-1:0] sixth_q [mrzs_pkg::SIXTH_NUM];
	logic         running_q;
	logic [IW-1:0] idx_q;
	logic [2:0]    sixth_idx;

	logic         res_valid_q, res_zero_q, res_last_q;
	logic [W-1:0] res_idx_q;

	logic         out_valid_q, step_valid_q, zero_hit_q, last_step_q;
	logic [W-1:0] term_index_q;

	logic          in_acc, out_free, bad_mod;
	logic          mul_start, mul_done;
	logic [AW-1:0] mul_a;
	logic [W-1:0]  mul_b, mul_res;
	logic [W:0]    diff;
	logic [W-1:0]  next_term;

	function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
	endfunction

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign bad_mod = (p_q < W'(3)) || !p_q[0];
	assign sixth_idx = 3'(idx_q - mrzs_pkg::IDX_SIXTH_FIRST);

	mrzs_mulmod #(.W(W), .AW(AW)) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.p(p_q),
		.done(mul_done),
		.result(mul_res)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrzs_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (start_req && !bad_mod) state_d = mrzs_pkg::ST_INIT_GO;
					else if (!start_req && running_q) state_d = mrzs_pkg::ST_M1_GO;
					else state_d = mrzs_pkg::ST_DONE;
				end
			end
			mrzs_pkg::ST_INIT_GO: state_d = mrzs_pkg::ST_INIT_WAIT;
			mrzs_pkg::ST_INIT_WAIT: begin
				if (mul_done) begin
					if (idx_q == mrzs_pkg::IDX_CUR) state_d = mrzs_pkg::ST_M1_GO;
					else state_d = mrzs_pkg::ST_INIT_GO;
				end
			end
			mrzs_pkg::ST_M1_GO: state_d = mrzs_pkg::ST_M1_WAIT;
			mrzs_pkg::ST_M1_WAIT: if (mul_done) state_d = mrzs_pkg::ST_M2_GO;
			mrzs_pkg::ST_M2_GO: state_d = mrzs_pkg::ST_M2_WAIT;
			mrzs_pkg::ST_M2_WAIT: if (mul_done) state_d = mrzs_pkg::ST_DONE;
			mrzs_pkg::ST_DONE: if (out_free) state_d = mrzs_pkg::ST_IDLE;
			default: state_d = mrzs_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine: handshake and multiplier operands.
	always_comb begin
		in_stall = 1'b1;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			mrzs_pkg::ST_IDLE: in_stall = 1'b0;
			mrzs_pkg::ST_INIT_GO: begin
				mul_start = 1'b1;
				mul_a = AW'(mrzs_pkg::INIT_CONST[idx_q]);
				mul_b = W'(1);
			end
			mrzs_pkg::ST_M1_GO: begin
				mul_start = 1'b1;
				mul_a = AW'(cubic_q[0]);
				mul_b = cur_q;
			end
			mrzs_pkg::ST_M2_GO: begin
				mul_start = 1'b1;
				mul_a = AW'(sixth_q[0]);
				mul_b = prev_q;
			end
			default: in_stall = 1'b1;
		endcase
	end

	// New term: t1 - t2 modulo p, the second product being in mul_res.
	always_comb begin
		diff = {1'b0, t1_q} - {1'b0, mul_res};
		if (t1_q >= mul_res) next_term = diff[W-1:0];
		else next_term = W'(diff + {1'b0, p_q});
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrzs_pkg::ST_IDLE;
			running_q <= 1'b0;
			p_q <= W'(7);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (modulus_wr) begin
				p_q <= modulus[W-1:0];
				running_q <= 1'b0;
			end else if (state_q == mrzs_pkg::ST_IDLE && in_acc && start_req) begin
				running_q <= !bad_mod;
			end else if (state_q == mrzs_pkg::ST_M2_WAIT && mul_done) begin
				running_q <= (r_q != p_q - W'(2));
			end
			if (state_q == mrzs_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers: scan state, pending result and output word.
	always_ff @(posedge clk) begin
		if (state_q == mrzs_pkg::ST_IDLE && in_acc) begin
			res_valid_q <= 1'b0;
			res_idx_q <= '0;
			res_zero_q <= 1'b0;
			res_last_q <= 1'b0;
			idx_q <= '0;
		end
		if (state_q == mrzs_pkg::ST_INIT_WAIT && mul_done) begin
			if (idx_q < mrzs_pkg::IDX_SIXTH_FIRST) cubic_q[idx_q[1:0]] <= mul_res;
			else if (idx_q < mrzs_pkg::IDX_PREV) sixth_q[sixth_idx] <= mul_res;
			else if (idx_q == mrzs_pkg::IDX_PREV) prev_q <= mul_res;
			else cur_q <= mul_res;
			idx_q <= idx_q + 1'b1;
			r_q <= W'(1);
		end
		if (state_q == mrzs_pkg::ST_M1_WAIT && mul_done) t1_q <= mul_res;
		// Step completion: shift terms, advance difference rows, form result.
		if (state_q == mrzs_pkg::ST_M2_WAIT && mul_done) begin
			prev_q <= cur_q;
			cur_q <= next_term;
			for (int k = 0; k < mrzs_pkg::CUBIC_NUM - 1; k++)
				cubic_q[k] <= mod_add(cubic_q[k], cubic_q[k+1], p_q);
			for (int k = 0; k < mrzs_pkg::SIXTH_NUM - 1; k++)
				sixth_q[k] <= mod_add(sixth_q[k], sixth_q[k+1], p_q);
			r_q <= r_q + 1'b1;
			res_valid_q <= 1'b1;
			res_idx_q <= r_q + 1'b1;
			res_zero_q <= (next_term == '0);
			res_last_q <= (r_q == p_q - W'(2));
		end
		if (state_q == mrzs_pkg::ST_DONE && out_free) begin
			step_valid_q <= res_valid_q;
			term_index_q <= res_idx_q;
			zero_hit_q <= res_zero_q;
			last_step_q <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign step_valid = step_valid_q;
	assign term_index = mrzs_pkg::FIELD_WIDTH'(term_index_q);
	assign zero_hit = zero_hit_q;
	assign last_step = last_step_q;

endmodule
`default_nettype wire

// ===== rtl/mrzs_checker.sv =====
`default_nettype none
// Port-level checks on the result channel.
module mrzs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        step_valid,
	input wire logic [30:0] term_index,
	input wire logic        zero_hit,
	input wire logic        last_step
);

	// A stalled word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// A word without a step carries no other information.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !step_valid |-> term_index == 31'd0 && !zero_hit && !last_step)
		else $error("idle word has nonzero fields");

	// A performed step always produces an index of at least two.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_valid |-> term_index > 31'd1)
		else $error("step reported with index below two");

	// The step word after an unfinished step advances the index by one, or is a restart at two.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && step_valid && !last_step ##1 out_valid && step_valid
		|-> term_index == $past(term_index) + 31'd1 || term_index == 31'd2)
		else $error("term index did not advance by one");

endmodule

bind modular_recurrence_zero_scan_top mrzs_checker u_mrzs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.step_valid(step_valid),
	.term_index(term_index),
	.zero_hit(zero_hit),
	.last_step(last_step)
);
`default_nettype wire

// ===== tb/sv/mrzs_scoreboard.sv =====
`timescale 1ns / 100ps
module mrzs_scoreboard (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             modulus_wr,
	input  wire logic [mrzs_pkg::FIELD_WIDTH-1:0] modulus,
	input  wire logic                             in_valid,
	input  wire logic                             in_stall,
	input  wire logic                             start_req,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic                             step_valid,
	input  wire logic [mrzs_pkg::FIELD_WIDTH-1:0] term_index,
	input  wire logic                             zero_hit,
	input  wire logic                             last_step,
	output int                                    errors,
	output int                                    pending
);

	localparam logic [31:0] MASK31 = 32'h7FFF_FFFF;

	typedef struct packed {
		logic        step_valid;
		logic [30:0] term_index;
		logic        zero_hit;
		logic        last_step;
	} scan_word_t;

	// Predicted scan state, residues held in Montgomery form.
	logic [31:0] prime_p;
	logic [31:0] term_prev;
	logic [31:0] term_cur;
	logic [31:0] cubic_row [4];
	logic [31:0] sixth_row [7];
	logic [31:0] next_r;
	logic [31:0] minus_pinv;
	logic        scanning;

	scan_word_t expected_words [$];

	// Montgomery product a*b/2^32 modulo p.
	function automatic logic [31:0] mont_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		logic [31:0] m;
		logic [63:0] sum;
		logic [31:0] res;
		prod = {32'd0, a} * {32'd0, b};
		m = prod[31:0] * minus_pinv;
		sum = (prod >> 32) + (({32'd0, prod[31:0]} + {32'd0, m} * {32'd0, prime_p}) >> 32);
		res = sum[31:0];
		return (res >= prime_p) ? res - prime_p : res;
	endfunction

	function automatic logic [31:0] to_mont(input logic [31:0] x);
		logic [63:0] v;
		v = {32'd0, x % prime_p} << 32;
		return 32'(v % {32'd0, prime_p});
	endfunction

	function automatic logic [31:0] add_mod(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] s;
		s = a + b;
		return (s >= prime_p) ? s - prime_p : s;
	endfunction

	// Works out the word that one accepted input produces and advances the state.
	function automatic scan_word_t advance_scan(input logic req);
		scan_word_t w;
		logic [31:0] inv;
		logic [31:0] t1, t2, nxt, r;
		w = '0;
		if (req) begin
			if (prime_p < 3 || prime_p[0] == 1'b0) begin
				scanning = 1'b0;
				return w;
			end
			cubic_row[0] = to_mont(117); cubic_row[1] = to_mont(418);
			cubic_row[2] = to_mont(510); cubic_row[3] = to_mont(204);
			sixth_row[0] = to_mont(1);    sixth_row[1] = to_mont(63);
			sixth_row[2] = to_mont(602);  sixth_row[3] = to_mont(2100);
			sixth_row[4] = to_mont(3360); sixth_row[5] = to_mont(2520);
			sixth_row[6] = to_mont(720);
			// Newton iteration doubles the correct low bits each round.
			inv = 32'd1;
			for (int i = 0; i < 5; i++)
				inv = inv * (32'd2 - prime_p * inv);
			minus_pinv = -inv;
			term_prev = to_mont(1);
			term_cur = to_mont(5);
			next_r = 32'd1;
			scanning = 1'b1;
		end else if (!scanning) begin
			return w;
		end
		r = next_r;
		t1 = mont_mul(cubic_row[0], term_cur);
		t2 = mont_mul(sixth_row[0], term_prev);
		nxt = (t1 >= t2) ? t1 - t2 : t1 + prime_p - t2;
		term_prev = term_cur;
		term_cur = nxt & MASK31;
		for (int k = 0; k < 3; k++)
			cubic_row[k] = add_mod(cubic_row[k], cubic_row[k+1]);
		for (int k = 0; k < 6; k++)
			sixth_row[k] = add_mod(sixth_row[k], sixth_row[k+1]);
		w.step_valid = 1'b1;
		w.term_index = 31'((r + 1) & MASK31);
		w.zero_hit = (nxt == 0);
		if (r == prime_p - 2) begin
			w.last_step = 1'b1;
			scanning = 1'b0;
		end
		next_r = (r + 1) & MASK31;
		return w;
	endfunction

	// Watch both channels and the register port; compare each result word.
	always @(posedge clk or negedge arst_n) begin
		scan_word_t got, want;
		if (!arst_n) begin
			prime_p = 32'd7;
			term_prev = '0;
			term_cur = '0;
			for (int k = 0; k < 4; k++) cubic_row[k] = '0;
			for (int k = 0; k < 7; k++) sixth_row[k] = '0;
			next_r = '0;
			minus_pinv = '0;
			scanning = 1'b0;
			expected_words.delete();
			errors = 0;
		end else begin
			if (modulus_wr) begin
				prime_p = {1'b0, modulus} & MASK31;
				scanning = 1'b0;
			end
			if (in_valid && !in_stall)
				expected_words.push_back(advance_scan(start_req));
			if (out_valid && !out_stall) begin
				got = '{step_valid, term_index, zero_hit, last_step};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, actual %p", $time, got);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.step_valid !== want.step_valid) begin
						$display("%0t: step_valid expected %0d actual %0d",
							$time, want.step_valid, got.step_valid);
						errors++;
					end
					if (got.term_index !== want.term_index) begin
						$display("%0t: term_index expected %0d actual %0d",
							$time, want.term_index, got.term_index);
						errors++;
					end
					if (got.zero_hit !== want.zero_hit) begin
						$display("%0t: zero_hit expected %0d actual %0d",
							$time, want.zero_hit, got.zero_hit);
						errors++;
					end
					if (got.last_step !== want.last_step) begin
						$display("%0t: last_step expected %0d actual %0d",
							$time, want.last_step, got.last_step);
						errors++;
					end
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

// ===== tb/sv/tb_modular_recurrence_zero_scan_top.sv =====
`timescale 1ns / 100ps
module tb_modular_recurrence_zero_scan_top;

	localparam logic REQ_START = 1'b1;
	localparam logic REQ_STEP = 1'b0;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 750;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             modulus_wr = 1'b0;
	logic [mrzs_pkg::FIELD_WIDTH-1:0] modulus = 31'd7;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             start_req = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             step_valid;
	logic [mrzs_pkg::FIELD_WIDTH-1:0] term_index;
	logic                             zero_hit;
	logic                             last_step;
	int                               errors;
	int                               pending;
	int                               words_sent = 0;
	int                               words_seen = 0;
	int                               quiet_cycles = 0;
	bit                               no_gaps = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	modular_recurrence_zero_scan_top #(.MOD_WIDTH(31)) DUT (
		.clk(clk), .arst_n(arst_n),
		.modulus_wr(modulus_wr), .modulus(modulus),
		.in_valid(in_valid), .in_stall(in_stall), .start_req(start_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_valid(step_valid), .term_index(term_index),
		.zero_hit(zero_hit), .last_step(last_step)
	);

	mrzs_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.modulus_wr(modulus_wr), .modulus(modulus),
		.in_valid(in_valid), .in_stall(in_stall), .start_req(start_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_valid(step_valid), .term_index(term_index),
		.zero_hit(zero_hit), .last_step(last_step),
		.errors(errors), .pending(pending)
	);

	// Count accepted words and end the run if the block goes quiet.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			words_seen++;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || modulus_wr)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stall runs, plus one long hold-off once words are flowing.
	initial begin
		bit held;
		int pick;
		held = 1'b0;
		forever begin
			if (!held && words_seen >= 60) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else if (pick < 92) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	// Offer one word and hold it until it is taken, then maybe leave a gap.
	task automatic send_word(input logic req);
		int pick, gap;
		in_valid <= 1'b1;
		start_req <= req;
		do @(posedge clk); while (in_stall);
		words_sent++;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 40)
			gap = 0;
		else if (pick < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let every result come back, then write the modulus while the block is idle.
	task automatic set_modulus(input logic [30:0] value);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		modulus_wr <= 1'b1;
		modulus <= value;
		@(posedge clk);
		modulus_wr <= 1'b0;
	endtask

	initial begin
		int steps;
		int pick;
		logic [30:0] pval;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle word before any start, then a full scan at the reset modulus.
		send_word(REQ_STEP);
		send_word(REQ_START);
		repeat (6) send_word(REQ_STEP);
		// An even modulus refuses the start.
		set_modulus(31'd8);
		send_word(REQ_START);
		send_word(REQ_STEP);
		// Largest modulus, with a restart in the middle of the scan.
		set_modulus(31'h7FFF_FFFF);
		send_word(REQ_START);
		send_word(REQ_STEP);
		send_word(REQ_START);
		send_word(REQ_STEP);
		// Odd composite modulus, then a write that cuts the scan short.
		set_modulus(31'd9);
		send_word(REQ_START);
		repeat (3) send_word(REQ_STEP);
		set_modulus(31'd9);
		send_word(REQ_STEP);
		set_modulus(31'h7FFF_FFFE);
		send_word(REQ_START);

		// Random scans, mostly with small moduli so that they run to the end.
		while (words_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				pval = 31'($urandom_range(3, 100) * 2 + 1);
				steps = pval + $urandom_range(0, 2);
			end else if (pick < 90) begin
				pval = 31'($urandom) | 31'd1;
				if (pval < 7)
					pval = 31'd7;
				steps = $urandom_range(5, 30);
			end else begin
				pval = 31'($urandom_range(4, 1000) * 2);
				steps = $urandom_range(2, 5);
			end
			set_modulus(pval);
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) send_word(REQ_STEP);
			send_word(REQ_START);
			repeat (steps) begin
				if ($urandom_range(0, 99) < 3)
					send_word(REQ_START);
				else
					send_word(REQ_STEP);
			end
		end
		no_gaps = 1'b0;

		// Drain and let the block settle before the verdict.
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
